>>> rtl/crs_pkg.sv
// shared types and constants of the credit request scheduler
// field widths, action, kind and register codes, queue item and result structs
// no dependencies
package crs_pkg;

	localparam int ACT_W     = 2;
	localparam int KIND_W    = 2;
	localparam int AMOUNT_W  = 40;
	localparam int FEM_W     = 5;
	localparam int MASK_W    = 32;
	localparam int THR_W     = 24;
	localparam int SIZE_W    = 24;
	localparam int SEQ_W     = 8;
	localparam int PEND_W    = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int QDEPTH    = 2;

	localparam logic [ACT_W-1:0] ACT_CMD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CREDIT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DATA   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNLIM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SIZED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT      = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET  = 24'd1024;
	localparam logic [CFG_W-1:0] INIT_RESET = 24'd4096;

	typedef enum logic [1:0] {
		OP_CMD    = 2'd0,
		OP_CREDIT = 2'd1,
		OP_DATA   = 2'd2
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [KIND_W-1:0]   kind;
		logic [AMOUNT_W-1:0] amount;
		logic [FEM_W-1:0]    first_fem;
		logic [FEM_W-1:0]    last_fem;
		logic [MASK_W-1:0]   mask;
		logic [FEM_W-1:0]    target;
	} item_t;

	typedef struct packed {
		logic [FEM_W-1:0]  fem;
		logic [SIZE_W-1:0] size;
		logic              frames;
		logic [SEQ_W-1:0]  seq;
		logic              present;
		logic              last;
	} result_t;

endpackage

>>> rtl/crs_front.sv
// front stage: accepts input beats, decodes the action and drops unknown ones
// depends on crs_pkg
module crs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [crs_pkg::ACT_W-1:0]     action,
	input  logic [crs_pkg::KIND_W-1:0]    request_kind,
	input  logic [crs_pkg::AMOUNT_W-1:0]  amount,
	input  logic [crs_pkg::FEM_W-1:0]     fem_first,
	input  logic [crs_pkg::FEM_W-1:0]     fem_last,
	input  logic [crs_pkg::MASK_W-1:0]    fem_mask,
	input  logic [crs_pkg::FEM_W-1:0]     target_fem,
	output logic                          push,
	output crs_pkg::item_t                push_item,
	input  logic                          push_ready
);
	import crs_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;
	logic  keep_c;

	always_comb begin
		item_c.op        = OP_CMD;
		item_c.kind      = request_kind;
		item_c.amount    = amount;
		item_c.first_fem = fem_first;
		item_c.last_fem  = fem_last;
		item_c.mask      = fem_mask;
		item_c.target    = target_fem;
		keep_c           = 1'b1;
		unique case (action)
			ACT_CMD:    item_c.op = OP_CMD;
			ACT_CREDIT: item_c.op = OP_CREDIT;
			ACT_DATA:   item_c.op = OP_DATA;
			default:    keep_c = 1'b0;
		endcase
	end

	assign in_ready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_c;
		end
	end

endmodule

>>> rtl/crs_queue.sv
// short queue of decoded items between front and back
// depends on crs_pkg
module crs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  crs_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output crs_pkg::item_t pop_item,
	input  logic           pop
);
	import crs_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/crs_back.sv
// back end: card state, configuration registers, card scan and result register
// depends on crs_pkg
module crs_back #(
	parameter int NUM_CARDS   = 32,
	parameter int CREDIT_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           q_valid,
	input  crs_pkg::item_t                 q_item,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output crs_pkg::result_t               out_res
);
	import crs_pkg::*;

	localparam int IDXW = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
	localparam logic [FEM_W:0] NUM_W = (FEM_W + 1)'(NUM_CARDS);
	localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} st_t;

	st_t                   state_q;
	logic [THR_W-1:0]      thr_q;
	logic                  frames_q;
	logic [CFG_W-1:0]      init_q;
	logic [CREDIT_BITS-1:0] credit_q [NUM_CARDS];
	logic [PEND_W-1:0]     pending_q [NUM_CARDS];
	logic [SEQ_W-1:0]      seq_q [NUM_CARDS];
	logic [NUM_CARDS-1:0]  first_q;
	logic [NUM_CARDS-1:0]  stop_q;
	logic                  unlim_q;
	logic [AMOUNT_W-1:0]   budget_q;
	logic [AMOUNT_W-1:0]   rcvd_q;
	logic [FEM_W:0]        idx_q;
	logic [FEM_W-1:0]      last_q;
	logic [MASK_W-1:0]     mask_q;
	result_t               held_q;
	logic                  hv_q;
	result_t               out_q;
	logic                  ov_q;

	logic [IDXW-1:0]        addr;
	logic [CREDIT_BITS-1:0] cur_credit;
	logic [PEND_W-1:0]      cur_pending;
	logic [SEQ_W-1:0]       cur_seq;
	logic                   cur_first;
	logic                   cur_stop;
	logic                   out_free;
	logic                   scan_done;
	logic                   sel;
	logic                   budget_zero;
	logic [CREDIT_BITS-1:0] size;
	logic                   send;
	logic                   can_go;
	logic                   scan_fire;
	logic                   scan_adv;
	logic                   load_out_mid;
	logic                   load_out_end;
	result_t                new_res;
	result_t                held_last;
	logic [AMOUNT_W:0]      ret_sum;
	logic [CREDIT_BITS-1:0] credit_ret;
	logic [PEND_W-1:0]      pending_ret;
	logic                   target_ok;
	logic [AMOUNT_W-1:0]    budget_rx;

	assign addr        = (state_q == ST_SCAN) ? idx_q[IDXW-1:0] : q_item.target[IDXW-1:0];
	assign cur_credit  = credit_q[addr];
	assign cur_pending = pending_q[addr];
	assign cur_seq     = seq_q[addr];
	assign cur_first   = first_q[addr];
	assign cur_stop    = stop_q[addr];

	assign out_free    = !ov_q || out_ready;
	assign scan_done   = (idx_q > {1'b0, last_q}) || (idx_q >= NUM_W);
	assign sel         = mask_q[idx_q[FEM_W-1:0]] && (32'(cur_credit) >= 32'(thr_q));
	assign budget_zero = budget_q == '0;

	always_comb begin
		if (budget_zero) begin
			size = '0;
		end else if (!frames_q && !unlim_q && (AMOUNT_W'(cur_credit) >= budget_q)) begin
			size = budget_q[CREDIT_BITS-1:0];
		end else begin
			size = cur_credit;
		end
	end

	// a stop request goes out once per card until a nonzero budget is seen
	assign send         = sel && (!budget_zero || unlim_q || !cur_stop);
	assign can_go       = !hv_q || out_free;
	assign scan_fire    = (state_q == ST_SCAN) && !scan_done && send && can_go;
	assign scan_adv     = (state_q == ST_SCAN) && !scan_done && (!send || can_go);
	assign load_out_mid = scan_fire && hv_q;
	assign load_out_end = (state_q == ST_FLUSH) && hv_q && out_free;
	assign q_pop        = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		new_res.fem     = idx_q[FEM_W-1:0];
		new_res.size    = SIZE_W'(size);
		new_res.frames  = frames_q;
		new_res.seq     = cur_first ? '0 : cur_seq;
		new_res.present = !cur_first;
		new_res.last    = 1'b0;
	end

	// held result marked as the final one of its command
	always_comb begin
		held_last      = held_q;
		held_last.last = 1'b1;
	end

	assign ret_sum     = {1'b0, q_item.amount} + (AMOUNT_W + 1)'(cur_credit);
	assign credit_ret  = (ret_sum > (AMOUNT_W + 1)'(CREDIT_MAX)) ? CREDIT_MAX
		: ret_sum[CREDIT_BITS-1:0];
	assign pending_ret = (q_item.amount >= AMOUNT_W'(cur_pending)) ? '0
		: cur_pending - q_item.amount[PEND_W-1:0];
	assign target_ok   = {1'b0, q_item.target} < NUM_W;
	assign budget_rx   = (q_item.amount >= budget_q) ? '0 : budget_q - q_item.amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			frames_q <= 1'b0;
			init_q   <= INIT_RESET;
			for (int i = 0; i < NUM_CARDS; i++) begin
				credit_q[i]  <= CREDIT_BITS'(INIT_RESET);
				pending_q[i] <= '0;
				seq_q[i]     <= '0;
			end
			first_q  <= '1;
			stop_q   <= '0;
			unlim_q  <= 1'b0;
			budget_q <= '0;
			rcvd_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESHOLD: thr_q <= cfg_data;
					CFG_FRAMES:    frames_q <= cfg_data[0];
					CFG_INIT: begin
						init_q <= cfg_data;
						for (int i = 0; i < NUM_CARDS; i++) begin
							credit_q[i] <= CREDIT_BITS'(cfg_data);
						end
					end
					default: ;
				endcase
			end
			if (q_pop) begin
				case (q_item.op)
					OP_CREDIT: begin
						if (target_ok) begin
							credit_q[addr]  <= credit_ret;
							pending_q[addr] <= pending_ret;
						end
					end
					OP_DATA: begin
						rcvd_q   <= rcvd_q + q_item.amount;
						budget_q <= budget_rx;
					end
					OP_CMD: begin
						case (q_item.kind)
							KIND_STOP: begin
								unlim_q  <= 1'b0;
								budget_q <= '0;
							end
							KIND_UNLIM: unlim_q <= 1'b1;
							KIND_SIZED: begin
								unlim_q  <= 1'b0;
								budget_q <= q_item.amount;
								if (q_item.amount != '0) begin
									rcvd_q <= '0;
								end
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			if (scan_fire) begin
				credit_q[addr]  <= cur_credit - size;
				pending_q[addr] <= cur_pending + PEND_W'(size);
				seq_q[addr]     <= cur_first ? '0 : cur_seq + 1'b1;
				first_q[addr]   <= size == '0;
				stop_q[addr]    <= budget_zero;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			hv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_item.op == OP_CMD)) begin
						idx_q   <= {1'b0, q_item.first_fem};
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FLUSH;
					end else if (scan_adv) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!hv_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (scan_fire) begin
				hv_q <= 1'b1;
			end else if (load_out_end) begin
				hv_q <= 1'b0;
			end
			if (load_out_mid || load_out_end) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.op == OP_CMD)) begin
			last_q <= q_item.last_fem;
			mask_q <= q_item.mask;
		end
		if (scan_fire) begin
			held_q <= new_res;
		end
		if (load_out_mid || load_out_end) begin
			out_q <= load_out_end ? held_last : held_q;
		end
	end

	assign out_valid = ov_q;
	assign out_res   = out_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hv_q)
		else $error("held result left over outside a scan");

	a_mid_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		load_out_mid |=> hv_q && ov_q)
		else $error("non-final result sent without a successor held");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_out_end |=> ov_q && out_q.last)
		else $error("final result of a command not marked last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !scan_done && send && !can_go) |=> $stable(idx_q))
		else $error("scan moved on while its result could not be stored");

endmodule

>>> rtl/credit_request_scheduler_core.sv
// top level of the credit request scheduler: front, queue and back end
// depends on crs_pkg, crs_front, crs_queue, crs_back
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------------
// in      | to block  | in_valid/in_ready   | action, request_kind, amount, fem_first,
//         |           |                     | fem_last, fem_mask, target_fem
// out     | from block| out_valid/out_ready | fem_index, request_size, unit_frames,
//         |           |                     | seq_number, seq_present, last_request
// cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// credit return and data beats pass the front stage register and the queue before
// the back end applies them
// a request command is served by the back end scan, which visits one card per cycle
// unless a full result register stalls it, through a single card state port
// after reset the block takes beats at once; no clearing pass
// a full result register stalls the scan, a busy back end fills the queue then the front
module credit_request_scheduler_core #(
	parameter int NUM_CARDS   = 32,
	parameter int CREDIT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crs_pkg::CFG_W-1:0]     cfg_data,
	// input beats
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [crs_pkg::ACT_W-1:0]     action,
	input  logic [crs_pkg::KIND_W-1:0]    request_kind,
	input  logic [crs_pkg::AMOUNT_W-1:0]  amount,
	input  logic [crs_pkg::FEM_W-1:0]     fem_first,
	input  logic [crs_pkg::FEM_W-1:0]     fem_last,
	input  logic [crs_pkg::MASK_W-1:0]    fem_mask,
	input  logic [crs_pkg::FEM_W-1:0]     target_fem,
	// result beats
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crs_pkg::FEM_W-1:0]     fem_index,
	output logic [crs_pkg::SIZE_W-1:0]    request_size,
	output logic                          unit_frames,
	output logic [crs_pkg::SEQ_W-1:0]     seq_number,
	output logic                          seq_present,
	output logic                          last_request
);
	import crs_pkg::*;

	// front to queue
	logic    push;
	item_t   push_item;
	logic    push_ready;
	// queue to back end
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	// result register contents
	result_t out_res;

	// decode and drop of unknown actions, one register stage
	crs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.request_kind (request_kind),
		.amount       (amount),
		.fem_first    (fem_first),
		.fem_last     (fem_last),
		.fem_mask     (fem_mask),
		.target_fem   (target_fem),
		.push         (push),
		.push_item    (push_item),
		.push_ready   (push_ready)
	);

	// decouples the front from a back end busy with a scan
	crs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	// card state, mode and budget, the scan and the result register
	crs_back #(
		.NUM_CARDS   (NUM_CARDS),
		.CREDIT_BITS (CREDIT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// result fields straight from the output register
	assign fem_index    = out_res.fem;
	assign request_size = out_res.size;
	assign unit_frames  = out_res.frames;
	assign seq_number   = out_res.seq;
	assign seq_present  = out_res.present;
	assign last_request = out_res.last;

endmodule
